@@ rtl/core/tcofq_pkg.sv @@
// Package for the two-class oldest-first queue.
// Holds command and status codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package tcofq_pkg;

  // Widths of the request and response fields
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;

  // Parameter defaults
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_BITS     = 16;
  localparam int unsigned DEF_STAMP_BITS  = 16;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Class codes
  localparam logic CLASS_FIRST  = 1'b0;
  localparam logic CLASS_SECOND = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

@@ rtl/core/tcofq_if.sv @@
// Request and response channel interfaces of the two-class oldest-first queue.
// Depends on tcofq_pkg.
`timescale 1ns / 1ps

interface tcofq_req_if
  import tcofq_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic            item_class;
  logic [ID_W-1:0] item_id;

  modport source (output valid, output cmd, output item_class, output item_id, input ready);
  modport sink   (input valid, input cmd, input item_class, input item_id, output ready);
endinterface

interface tcofq_rsp_if
  import tcofq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                out_class;
  logic [ID_W-1:0]     out_id;

  modport source (output valid, output status, output out_class, output out_id, input ready);
  modport sink   (input valid, input status, input out_class, input out_id, output ready);
endinterface

@@ rtl/core/tcofq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcofq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/two_class_oldest_first_queue_top.sv @@
// Two-class oldest-first queue: two FIFOs, one per class, sharing one arrival stamp.
// Depends on tcofq_pkg, tcofq_if (tcofq_req_if, tcofq_rsp_if) and tcofq_ram.
`timescale 1ns / 1ps

// Each request is an enqueue (item id into the queue of its class, tagged with
// the shared arrival stamp) or a dequeue of the oldest item of either class.
// Every request yields exactly one response: enqueued, delivered (with class
// and id), both queues empty, or class queue full. Stamps wrap; age is taken
// from the sign bit of the modular difference of the two head stamps, which
// is exact while the held items span less than half the stamp range. On a
// stamp tie the second class wins. An enqueue, and a dequeue with both queues
// empty, are answered straight from ST_IDLE; a dequeue of an item passes
// through ST_PICK, which waits for the registered read of the head entries
// from the two queue memories. One request is in flight at a time; the
// response register lets the next request enter while the response is being
// taken. The memories need no clearing: entry data is only used once written.
module two_class_oldest_first_queue_top
  import tcofq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = DEF_ID_BITS,
  parameter int unsigned STAMP_BITS  = DEF_STAMP_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcofq_req_if.sink   req_i,
  tcofq_rsp_if.source rsp_o
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_BITS + STAMP_BITS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PICK = 1'b1;

  logic state_q, state_d;

  // Queue pointers and counts, index 0 first class, 1 second class
  logic [PTR_W-1:0] head_q  [2];
  logic [PTR_W-1:0] head_d  [2];
  logic [PTR_W-1:0] tail_q  [2];
  logic [PTR_W-1:0] tail_d  [2];
  logic [CNT_W-1:0] count_q [2];
  logic [CNT_W-1:0] count_d [2];
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;

  // Response register
  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic                rsp_class_q, rsp_class_d;
  logic [ID_W-1:0]     rsp_id_q, rsp_id_d;

  // Memory ports
  logic               we       [2];
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata    [2];

  logic accept;
  logic [ID_BITS-1:0] in_id;
  logic [STAMP_BITS-1:0] stamp_diff;
  logic take_first;
  logic pop_cls;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Take a new request only when idle and the response slot is free or draining
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign in_id       = ID_BITS'(req_i.item_id);
  assign wdata       = {in_id, stamp_q};

  // Head entries are always read; in ST_PICK the data belongs to the heads
  // sampled at the accept edge (heads do not move in between)
  for (genvar c = 0; c < 2; c++) begin : g_queue
    tcofq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[c]),
      .waddr_i (tail_q[c]),
      .wdata_i (wdata),
      .raddr_i (head_q[c]),
      .rdata_o (rdata[c])
    );
  end

  // Older head: first class wins when (first - second) is negative mod 2^N
  assign stamp_diff = rdata[0][STAMP_BITS-1:0] - rdata[1][STAMP_BITS-1:0];
  assign take_first = (count_q[1] == '0) ||
                      ((count_q[0] != '0) && stamp_diff[STAMP_BITS-1]);
  assign pop_cls    = take_first ? CLASS_FIRST : CLASS_SECOND;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    stamp_d      = stamp_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_class_d  = rsp_class_q;
    rsp_id_d     = rsp_id_q;
    we[0]        = 1'b0;
    we[1]        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.cmd == CMD_ENQ) begin
            rsp_valid_d = 1'b1;
            rsp_class_d = CLASS_FIRST;
            rsp_id_d    = '0;
            if (count_q[req_i.item_class] == CNT_FULL) begin
              rsp_status_d = ST_FULL;
            end else begin
              rsp_status_d                 = ST_ENQUEUED;
              we[req_i.item_class]         = 1'b1;
              tail_d[req_i.item_class]     = next_ptr(tail_q[req_i.item_class]);
              count_d[req_i.item_class]    = count_q[req_i.item_class] + CNT_W'(1);
              stamp_d                      = stamp_q + STAMP_BITS'(1);
            end
          end else if (count_q[0] == '0 && count_q[1] == '0) begin
            rsp_valid_d  = 1'b1;
            rsp_status_d = ST_EMPTY;
            rsp_class_d  = CLASS_FIRST;
            rsp_id_d     = '0;
          end else begin
            state_d = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        // Response slot is free here: it was free or draining at accept
        rsp_valid_d       = 1'b1;
        rsp_status_d      = ST_DELIVERED;
        rsp_class_d       = pop_cls;
        rsp_id_d          = ID_W'(rdata[pop_cls][ENTRY_W-1:STAMP_BITS]);
        head_d[pop_cls]   = next_ptr(head_q[pop_cls]);
        count_d[pop_cls]  = count_q[pop_cls] - CNT_W'(1);
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      tail_q[0]   <= '0;
      tail_q[1]   <= '0;
      count_q[0]  <= '0;
      count_q[1]  <= '0;
      stamp_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      stamp_q     <= stamp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_status_q <= rsp_status_d;
    rsp_class_q  <= rsp_class_d;
    rsp_id_q     <= rsp_id_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.out_class = rsp_class_q;
  assign rsp_o.out_id    = rsp_id_q;

endmodule
